/* rtl/ptgb_pkg.sv */
`timescale 1ns / 1ps

package ptgb_pkg;

	localparam int SLOTS       = 8;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W       = $clog2(SLOTS + 1);

	localparam int ELAPSED_W   = 20;
	localparam int PERIOD_W    = 23;
	localparam int PERIOD_US_W = 33;
	localparam int ACC_W       = 40;
	localparam int USES_W      = 16;
	localparam int US_PER_MS   = 1000;

	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QLVL_W      = $clog2(QDEPTH + 1);

	localparam int S_TDATA_W   = 48;
	localparam int S_TUSER_W   = 3;
	localparam int M_TDATA_W   = 24;
	localparam int M_TUSER_W   = 2;

	typedef enum logic [S_TUSER_W-1:0] {
		ACT_TICK   = 3'd0,
		ACT_ADD    = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_RESET  = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef enum logic [M_TUSER_W-1:0] {
		RES_FIRED = 2'd0,
		RES_ADDED = 2'd1,
		RES_FULL  = 2'd2
	} result_kind_t;

	typedef struct packed {
		action_t                action;
		logic [ELAPSED_W-1:0]   elapsed;
		logic [PERIOD_W-1:0]    period;
		logic [PERIOD_US_W-1:0] period_us;
	} cmd_t;

endpackage

/* rtl/ptgb_front.sv */
`timescale 1ns / 1ps

module ptgb_front import ptgb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_t                 cmd
);

	logic                 valid_s1;
	logic                 known_s1;
	logic [S_TUSER_W-1:0] action_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic [PERIOD_W-1:0]  period_s1;
	logic                 known;
	logic                 take;

	always_comb begin
		unique case (s_axis_tuser)
			ACT_TICK, ACT_ADD, ACT_REMOVE, ACT_RESET, ACT_CLEAR: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	// Items with an unused action are dropped here and never reach the queue.
	assign s_axis_tready = !valid_s1 || !known_s1 || cmd_ready;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			known_s1   <= known;
			action_s1  <= s_axis_tuser;
			elapsed_s1 <= s_axis_tdata[ELAPSED_W-1:0];
			period_s1  <= s_axis_tdata[ELAPSED_W+PERIOD_W-1:ELAPSED_W];
		end
	end

	assign cmd_valid     = valid_s1 && known_s1;
	assign cmd.action    = action_t'(action_s1);
	assign cmd.elapsed   = elapsed_s1;
	assign cmd.period    = period_s1;
	assign cmd.period_us = PERIOD_US_W'(period_s1) * PERIOD_US_W'(US_PER_MS);

endmodule

/* rtl/ptgb_fifo.sv */
`timescale 1ns / 1ps

module ptgb_fifo import ptgb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (level_q != QLVL_W'(QDEPTH));
	assign pop_valid  = (level_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + QLVL_W'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - QLVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/ptgb_back.sv */
`timescale 1ns / 1ps

module ptgb_back import ptgb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  cmd_t                cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output result_kind_t        out_kind,
	output logic [PERIOD_W-1:0] out_period,
	output logic                out_last,
	output logic [CNT_W-1:0]    slot_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_ADD,
		ST_REMOVE
	} state_t;

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [CNT_W-1:0]       idx_q, idx_d;
	logic [CNT_W-1:0]       wr_q, wr_d;
	logic                   pend_valid_q, pend_valid_d;
	logic                   out_valid_q, out_valid_d;
	cmd_t                   cur_q;
	logic [PERIOD_W-1:0]    pend_period_q;
	result_kind_t           out_kind_q;
	logic [PERIOD_W-1:0]    out_period_q;
	logic                   out_last_q;

	logic [PERIOD_W-1:0]    slot_period_q    [SLOTS];
	logic [PERIOD_US_W-1:0] slot_period_us_q [SLOTS];
	logic [ACC_W-1:0]       slot_acc_q       [SLOTS];
	logic [USES_W-1:0]      slot_uses_q      [SLOTS];

	logic [SLOT_W-1:0]      rd_idx;
	logic [PERIOD_W-1:0]    rd_period;
	logic [PERIOD_US_W-1:0] rd_period_us;
	logic [ACC_W-1:0]       rd_acc;
	logic [USES_W-1:0]      rd_uses;

	logic [ACC_W:0]         sum;
	logic [ACC_W-1:0]       sat;
	logic [ACC_W-1:0]       per_us;
	logic                   fire;
	logic [USES_W-1:0]      new_uses;

	logic                   walk_end;
	logic                   out_free;
	logic                   out_load;
	result_kind_t           out_kind_n;
	logic [PERIOD_W-1:0]    out_period_n;
	logic                   out_last_n;
	logic                   pend_load;
	logic                   cur_load;
	logic                   acc_clear;
	logic                   slot_we;
	logic [SLOT_W-1:0]      slot_wa;
	logic [PERIOD_W-1:0]    w_period;
	logic [PERIOD_US_W-1:0] w_period_us;
	logic [ACC_W-1:0]       w_acc;
	logic [USES_W-1:0]      w_uses;

	assign rd_idx       = idx_q[SLOT_W-1:0];
	assign rd_period    = slot_period_q[rd_idx];
	assign rd_period_us = slot_period_us_q[rd_idx];
	assign rd_acc       = slot_acc_q[rd_idx];
	assign rd_uses      = slot_uses_q[rd_idx];

	assign sum    = {1'b0, rd_acc} + (ACC_W+1)'(cur_q.elapsed);
	assign sat    = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
	assign per_us = ACC_W'(rd_period_us);
	assign fire   = (sat > per_us);

	assign new_uses = (rd_period == cur_q.period && rd_uses != '0) ?
		rd_uses - USES_W'(1) : rd_uses;

	assign walk_end  = (idx_q == cnt_q);
	assign out_free  = !out_valid_q || out_ready;
	assign cmd_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		idx_d        = idx_q;
		wr_d         = wr_q;
		pend_valid_d = pend_valid_q;
		out_load     = 1'b0;
		out_kind_n   = RES_FIRED;
		out_period_n = pend_period_q;
		out_last_n   = 1'b0;
		pend_load    = 1'b0;
		cur_load     = 1'b0;
		acc_clear    = 1'b0;
		slot_we      = 1'b0;
		slot_wa      = rd_idx;
		w_period     = rd_period;
		w_period_us  = rd_period_us;
		w_acc        = rd_acc;
		w_uses       = rd_uses;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cur_load = 1'b1;
					idx_d    = '0;
					wr_d     = '0;
					unique case (cmd.action)
						ACT_TICK:   state_d = ST_TICK;
						ACT_ADD:    state_d = ST_ADD;
						ACT_REMOVE: state_d = ST_REMOVE;
						ACT_RESET:  acc_clear = 1'b1;
						ACT_CLEAR:  cnt_d = '0;
						default:    ;
					endcase
				end
			end
			ST_TICK: begin
				// A fired result is held back until the next one fires or the walk ends, so the final one can carry last.
				if (walk_end) begin
					if (!pend_valid_q) begin
						state_d = ST_IDLE;
					end else if (out_free) begin
						out_load     = 1'b1;
						out_last_n   = 1'b1;
						pend_valid_d = 1'b0;
						state_d      = ST_IDLE;
					end
				end else if (!(fire && pend_valid_q && !out_free)) begin
					slot_we = 1'b1;
					w_acc   = fire ? sat - per_us : sat;
					if (fire) begin
						out_load     = pend_valid_q;
						pend_load    = 1'b1;
						pend_valid_d = 1'b1;
					end
					idx_d = idx_q + CNT_W'(1);
				end
			end
			ST_ADD: begin
				if (walk_end) begin
					if (out_free) begin
						out_load     = 1'b1;
						out_period_n = cur_q.period;
						out_last_n   = 1'b1;
						state_d      = ST_IDLE;
						if (cnt_q == CNT_W'(SLOTS)) begin
							out_kind_n = RES_FULL;
						end else begin
							out_kind_n  = RES_ADDED;
							slot_we     = 1'b1;
							slot_wa     = cnt_q[SLOT_W-1:0];
							w_period    = cur_q.period;
							w_period_us = cur_q.period_us;
							w_acc       = '0;
							w_uses      = USES_W'(1);
							cnt_d       = cnt_q + CNT_W'(1);
						end
					end
				end else if (rd_period == cur_q.period) begin
					if (out_free) begin
						out_load     = 1'b1;
						out_kind_n   = RES_ADDED;
						out_period_n = cur_q.period;
						out_last_n   = 1'b1;
						slot_we      = 1'b1;
						w_uses       = (rd_uses == '1) ? rd_uses : rd_uses + USES_W'(1);
						state_d      = ST_IDLE;
					end
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			ST_REMOVE: begin
				// Decrement and compaction share one pass: live slots move down to wr_q.
				if (walk_end) begin
					cnt_d   = wr_q;
					state_d = ST_IDLE;
				end else begin
					if (new_uses != '0) begin
						slot_we = 1'b1;
						slot_wa = wr_q[SLOT_W-1:0];
						w_uses  = new_uses;
						wr_d    = wr_q + CNT_W'(1);
					end
					idx_d = idx_q + CNT_W'(1);
				end
			end
			default: state_d = ST_IDLE;
		endcase

		out_valid_d = out_load || (out_valid_q && !out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			wr_q         <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			idx_q        <= idx_d;
			wr_q         <= wr_d;
			pend_valid_q <= pend_valid_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cur_load) begin
			cur_q <= cmd;
		end
		if (pend_load) begin
			pend_period_q <= rd_period;
		end
		if (out_load) begin
			out_kind_q   <= out_kind_n;
			out_period_q <= out_period_n;
			out_last_q   <= out_last_n;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (acc_clear) begin
				slot_acc_q[i] <= '0;
			end
		end
		if (slot_we) begin
			slot_period_q[slot_wa]    <= w_period;
			slot_period_us_q[slot_wa] <= w_period_us;
			slot_acc_q[slot_wa]       <= w_acc;
			slot_uses_q[slot_wa]      <= w_uses;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_period = out_period_q;
	assign out_last   = out_last_q;
	assign slot_count = cnt_q;

endmodule

/* rtl/periodic_tick_generator_bank.sv */
`timescale 1ns / 1ps

// Bank of up to SLOTS periodic tick channels. A front stage takes one item per cycle into a
// four-entry command queue while the queue has room, and a back stage carries out one command
// at a time by walking the channel table one slot per cycle unless the walk stalls. A tick or
// a remove walks all live channels, an add walks them up to a matching period, and a reset
// or a clear needs no walk. Results leave through an output register, and the walk stalls
// only when a new result meets an unclaimed one. A tick emits one item per fired channel in
// table order with tlast on the final one and nothing if none fires; an add always emits one
// item with tlast set. Remove, reset, clear and unused actions emit nothing.
module periodic_tick_generator_bank import ptgb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // elapsed_us, period_ms, zero fill
	input  logic [S_TUSER_W-1:0] s_axis_tuser,  // action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // period_out, zero fill
	output logic [M_TUSER_W-1:0] m_axis_tuser,  // result_kind
	output logic                 m_axis_tlast
);

	logic                q_push_valid;
	logic                q_push_ready;
	cmd_t                q_push;
	logic                q_pop_valid;
	logic                q_pop_ready;
	cmd_t                q_pop;
	result_kind_t        out_kind;
	logic [PERIOD_W-1:0] out_period;
	logic [CNT_W-1:0]    slot_count;

	ptgb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd_valid     (q_push_valid),
		.cmd_ready     (q_push_ready),
		.cmd           (q_push)
	);

	ptgb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop)
	);

	ptgb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_pop_valid),
		.cmd_ready  (q_pop_ready),
		.cmd        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_kind   (out_kind),
		.out_period (out_period),
		.out_last   (m_axis_tlast),
		.slot_count (slot_count)
	);

	assign m_axis_tuser = out_kind;
	assign m_axis_tdata = {{(M_TDATA_W - PERIOD_W){1'b0}}, out_period};

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_count <= CNT_W'(SLOTS))
		else $error("channel count above table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (int'(slot_count) <= int'($past(slot_count)) + 1))
		else $error("channel count grew by more than one");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop_valid && q_pop_ready && q_pop.action == ACT_CLEAR) |=> (slot_count == '0))
		else $error("clear left channels in the table");

	a_add_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != RES_FIRED) |-> m_axis_tlast)
		else $error("add answer without last");
`endif

endmodule
